// ===== rtl/core/stb_pkg.sv =====
// Shared types and constants for the software timer bank.
// No dependencies; every other file in rtl/core refers to this package.
`default_nettype none

package stb_pkg;

    localparam int unsigned OP_W    = 2;
    localparam int unsigned SLOT_W  = 4;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned MASK_W  = 16;

    typedef logic [OP_W-1:0]    op_word_t;
    typedef logic [SLOT_W-1:0]  slot_t;
    typedef logic [VALUE_W-1:0] value_t;
    typedef logic [MASK_W-1:0]  mask_t;

    typedef enum logic [OP_W-1:0] {
        OP_DEFINE = 2'd0,
        OP_START  = 2'd1,
        OP_STOP   = 2'd2,
        OP_TICK   = 2'd3
    } op_t;

    // Per-slot strobes, qualified by the step enable; all but tick_en also by the slot match
    typedef struct packed {
        logic define_en;
        logic start_en;
        logic stop_en;
        logic tick_en;
    } lane_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/stb_req_if.sv =====
// Request channel of the timer bank: valid/ready plus one command word.
// Depends on stb_pkg for field types.
`default_nettype none

interface stb_req_if;

    logic              valid;
    logic              ready;
    stb_pkg::op_word_t operation;
    stb_pkg::slot_t    timer_slot;
    stb_pkg::value_t   reload_value;
    logic              auto_reload;

    modport source (
        output valid,
        output operation,
        output timer_slot,
        output reload_value,
        output auto_reload,
        input  ready
    );

    modport sink (
        input  valid,
        input  operation,
        input  timer_slot,
        input  reload_value,
        input  auto_reload,
        output ready
    );

endinterface

`default_nettype wire

// ===== rtl/core/stb_rsp_if.sv =====
// Result channel of the timer bank: valid/ready plus one result word.
// Depends on stb_pkg for field types.
`default_nettype none

interface stb_rsp_if;

    logic           valid;
    logic           ready;
    stb_pkg::mask_t fired_mask;
    stb_pkg::mask_t running_mask;
    logic           status;

    modport source (
        output valid,
        output fired_mask,
        output running_mask,
        output status,
        input  ready
    );

    modport sink (
        input  valid,
        input  fired_mask,
        input  running_mask,
        input  status,
        output ready
    );

endinterface

`default_nettype wire

// ===== rtl/core/stb_lane.sv =====
// One countdown slot: reload value, count, mode, running and defined flags.
// Depends on stb_pkg for the command struct and value type.
`default_nettype none

module stb_lane (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire stb_pkg::lane_cmd_t cmd,
    input  wire stb_pkg::value_t    load_value,
    input  wire logic               load_auto,
    output logic                    fired,
    output logic                    running_after,
    output logic                    defined
);

    stb_pkg::value_t reload_reg;
    stb_pkg::value_t reload_next;
    stb_pkg::value_t count_reg;
    stb_pkg::value_t count_next;
    logic            mode_reg;
    logic            mode_next;
    logic            running_reg;
    logic            running_next;
    logic            defined_reg;
    logic            defined_next;
    logic            expire;

    // Count of one reaches zero on this tick
    assign expire = cmd.tick_en && running_reg
                    && (count_reg == stb_pkg::value_t'(1));

    always_comb
    begin
        reload_next  = reload_reg;
        count_next   = count_reg;
        mode_next    = mode_reg;
        running_next = running_reg;
        defined_next = defined_reg;
        priority if (cmd.define_en)
        begin
            reload_next  = load_value;
            count_next   = load_value;
            mode_next    = load_auto;
            running_next = 1'b0;
            defined_next = 1'b1;
        end
        else if (cmd.start_en && defined_reg)
        begin
            running_next = 1'b1;
        end
        else if (cmd.stop_en && defined_reg)
        begin
            running_next = 1'b0;
            count_next   = reload_reg;
        end
        else if (expire)
        begin
            // reload; one-shot slots drop out of the running set
            count_next   = reload_reg;
            running_next = mode_reg;
        end
        else if (cmd.tick_en && running_reg)
        begin
            count_next = count_reg - stb_pkg::value_t'(1);
        end
        else
        begin
            // hold the slot as it is
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        reload_reg <= reload_next;
        count_reg  <= count_next;
        mode_reg   <= mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            defined_reg <= 1'b0;
        end
        else
        begin
            running_reg <= running_next;
            defined_reg <= defined_next;
        end
    end

    assign fired         = expire;
    assign running_after = running_next;
    assign defined       = defined_reg;

endmodule

`default_nettype wire

// ===== rtl/core/software_timer_bank.sv =====
// Top level of the software timer bank: input register, slot lanes, result register.
// Depends on stb_pkg, stb_req_if, stb_rsp_if and stb_lane.
//
//  channel   | dir | word contents                                   | accepted when
//  ----------+-----+-------------------------------------------------+----------------
//  request   | in  | operation, timer_slot, reload_value, auto_reload| valid && ready
//  result    | out | fired_mask, running_mask, status                | valid && ready
//
// One request word a cycle is taken into the input register while ready is high; its
// result word is then loaded into the result register and taken from there. Every slot
// counts in its own lane, so define, start, stop and tick each finish in the single pass.
// A stalled result holds the result register; one further request word is then
// held in the input register and ready drops until the result is taken.
// Reset clears all slots to undefined and stopped and empties both registers.
`default_nettype none

module software_timer_bank #(
    parameter int unsigned NUM_TIMERS = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    stb_req_if.sink    request,
    stb_rsp_if.source  result
);

    // Input register
    logic              in_valid_reg;
    stb_pkg::op_t      op_reg;
    stb_pkg::slot_t    slot_reg;
    stb_pkg::value_t   value_reg;
    logic              auto_reg;

    // Result register
    logic              out_valid_reg;
    stb_pkg::mask_t    fired_reg;
    stb_pkg::mask_t    running_reg;
    logic              status_reg;

    logic              advance;
    logic              take_in;
    stb_pkg::value_t   load_value;
    logic              start_or_stop;
    logic              defined_hit;
    logic              status_next;
    stb_pkg::mask_t    fired_next;
    stb_pkg::mask_t    running_next;

    logic [NUM_TIMERS-1:0] slot_hit;
    logic [NUM_TIMERS-1:0] lane_fired;
    logic [NUM_TIMERS-1:0] lane_running;
    logic [NUM_TIMERS-1:0] lane_defined;

    // Advance the held word whenever the result register is free or draining
    assign advance = in_valid_reg && (!out_valid_reg || result.ready);
    assign take_in = request.valid && request.ready;
    assign request.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (request.ready)
        begin
            in_valid_reg <= request.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            op_reg    <= stb_pkg::op_t'(request.operation);
            slot_reg  <= request.timer_slot;
            value_reg <= request.reload_value;
            auto_reg  <= request.auto_reload;
        end
    end

    // A zero reload value counts as one tick
    assign load_value = (value_reg == '0) ? stb_pkg::value_t'(1) : value_reg;

    genvar i;
    generate
        for (i = 0; i < NUM_TIMERS; i++)
        begin : g_lane
            stb_pkg::lane_cmd_t cmd;

            // Slots past the four-bit address range never match and stay idle
            assign slot_hit[i]   = (32'(slot_reg) == 32'(i));
            assign cmd.define_en = advance && (op_reg == stb_pkg::OP_DEFINE) && slot_hit[i];
            assign cmd.start_en  = advance && (op_reg == stb_pkg::OP_START) && slot_hit[i];
            assign cmd.stop_en   = advance && (op_reg == stb_pkg::OP_STOP) && slot_hit[i];
            assign cmd.tick_en   = advance && (op_reg == stb_pkg::OP_TICK);

            stb_lane u_lane (
                .clk           (clk),
                .rst_n         (rst_n),
                .cmd           (cmd),
                .load_value    (load_value),
                .load_auto     (auto_reg),
                .fired         (lane_fired[i]),
                .running_after (lane_running[i]),
                .defined       (lane_defined[i])
            );
        end

        // Only the low sixteen slots appear in the masks
        for (i = 0; i < stb_pkg::MASK_W; i++)
        begin : g_mask
            if (i < NUM_TIMERS)
            begin : g_live
                assign fired_next[i]   = lane_fired[i];
                assign running_next[i] = lane_running[i];
            end
            else
            begin : g_absent
                assign fired_next[i]   = 1'b0;
                assign running_next[i] = 1'b0;
            end
        end
    endgenerate

    // Start or stop on a slot that is out of range or never defined is an error
    assign start_or_stop = (op_reg == stb_pkg::OP_START) || (op_reg == stb_pkg::OP_STOP);
    assign defined_hit   = |(slot_hit & lane_defined);
    assign status_next   = start_or_stop && !defined_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            fired_reg   <= fired_next;
            running_reg <= running_next;
            status_reg  <= status_next;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.fired_mask   = fired_reg;
    assign result.running_mask = running_reg;
    assign result.status       = status_reg;

endmodule

`default_nettype wire

// ===== sim/software_timer_bank_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for software_timer_bank: directed and random command words.
// Depends on stb_pkg, stb_req_if and stb_rsp_if from rtl/core, and on the block itself.

module software_timer_bank_tb;

    localparam int unsigned SLOTS        = 16;
    localparam int unsigned RANDOM_WORDS = 400;
    localparam int unsigned IDLE_LIMIT   = 2000;  // cycles with no word moving on either side
    localparam int unsigned REPORT_MAX   = 10;
    localparam int unsigned HOLD_CYCLES  = 64;    // long receiver hold-off
    localparam int unsigned HOLD_AT_WORD = 120;
    localparam logic        STATUS_UNDEFINED = 1'b1;

    // One result word as the bank reports it
    typedef struct packed {
        stb_pkg::mask_t fired;
        stb_pkg::mask_t running;
        logic           status;
    } timer_result_t;

    // Scoreboard: tracks the timer bank state and queues the result word that each
    // accepted command must produce, then compares arriving results in order.
    class timer_bank_tracker;
        stb_pkg::value_t reload_q [SLOTS];
        stb_pkg::value_t count_q  [SLOTS];
        stb_pkg::mask_t  periodic_q;
        stb_pkg::mask_t  running_q;
        stb_pkg::mask_t  defined_q;
        timer_result_t   expected_results [$];
        int unsigned     mismatches;
        int unsigned     results_seen;
        int unsigned     op_count [4];
        int unsigned     firing_ticks;
        int unsigned     undefined_hits;

        function new();
            periodic_q     = '0;
            running_q      = '0;
            defined_q      = '0;
            mismatches     = 0;
            results_seen   = 0;
            firing_ticks   = 0;
            undefined_hits = 0;
            foreach (op_count[i]) op_count[i] = 0;
            foreach (reload_q[i])
            begin
                reload_q[i] = '0;
                count_q[i]  = '0;
            end
        endfunction

        function void note_command(stb_pkg::op_t op, stb_pkg::slot_t slot,
                                   stb_pkg::value_t value, logic periodic);
            timer_result_t want;
            want = '0;
            op_count[op]++;
            unique case (op)
                stb_pkg::OP_DEFINE:
                begin
                    reload_q[slot]   = (value == '0) ? stb_pkg::value_t'(1) : value;
                    count_q[slot]    = reload_q[slot];
                    periodic_q[slot] = periodic;
                    running_q[slot]  = 1'b0;
                    defined_q[slot]  = 1'b1;
                end
                stb_pkg::OP_START, stb_pkg::OP_STOP:
                begin
                    if (!defined_q[slot])
                    begin
                        want.status = STATUS_UNDEFINED;
                        undefined_hits++;
                    end
                    else if (op == stb_pkg::OP_START)
                        running_q[slot] = 1'b1;
                    else
                    begin
                        running_q[slot] = 1'b0;
                        count_q[slot]   = reload_q[slot];
                    end
                end
                stb_pkg::OP_TICK:
                begin
                    for (int i = 0; i < SLOTS; i++)
                    begin
                        if (running_q[i])
                        begin
                            count_q[i] = count_q[i] - stb_pkg::value_t'(1);
                            if (count_q[i] == '0)
                            begin
                                want.fired[i] = 1'b1;
                                count_q[i]    = reload_q[i];
                                if (!periodic_q[i])
                                    running_q[i] = 1'b0;
                            end
                        end
                    end
                    if (want.fired != '0)
                        firing_ticks++;
                end
            endcase
            want.running = running_q;
            expected_results.push_back(want);
        endfunction

        function void check_result(timer_result_t got);
            timer_result_t want;
            results_seen++;
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] result word with nothing expected: %s%h %s%h %s%b",
                             $time, "fired=", got.fired, "running=", got.running,
                             "status=", got.status);
                return;
            end
            want = expected_results.pop_front();
            if (got.fired !== want.fired || got.running !== want.running
                || got.status !== want.status)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] result %0d: fired exp %h got %h, %s %h got %h, %s %b got %b",
                             $time, results_seen, want.fired, got.fired,
                             "running exp", want.running, got.running,
                             "status exp", want.status, got.status);
            end
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic steady_flow;   // both sides run with no idling
    logic output_hold;   // receiver holds off to back the bank up
    int unsigned words_in;
    timer_bank_tracker tracker_h;

    stb_req_if request_bus ();
    stb_rsp_if result_bus ();

    software_timer_bank #(
        .NUM_TIMERS (SLOTS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_bus),
        .result  (result_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Mostly short gaps, now and then a long one
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        else if (roll < 85)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    // Small periods so that slots actually expire; zero and full-width now and then
    function automatic stb_pkg::value_t pick_reload();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        case (roll)
            0:       return '0;
            1:       return $urandom;
            2:       return $urandom_range(6, 40);
            default: return $urandom_range(1, 5);
        endcase
    endfunction

    // Offer one command word and hold it until the bank takes it.
    // Called at a rising edge; returns at the edge where the word was accepted.
    task automatic issue(stb_pkg::op_t op, stb_pkg::slot_t slot, stb_pkg::value_t value,
                         logic periodic);
        int unsigned gap;
        gap = steady_flow ? 0 : pick_gap();
        if (gap > 0)
        begin
            request_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_bus.valid        <= 1'b1;
        request_bus.operation    <= op;
        request_bus.timer_slot   <= slot;
        request_bus.reload_value <= value;
        request_bus.auto_reload  <= periodic;
        do
            @(posedge clk);
        while (!request_bus.ready);
        tracker_h.note_command(op, slot, value, periodic);
        words_in++;
    endtask

    // Commands other than define carry random filler in the unused fields
    task automatic issue_plain(stb_pkg::op_t op, stb_pkg::slot_t slot);
        issue(op, slot, $urandom, 1'($urandom));
    endtask

    initial
    begin : stimulus
        int unsigned roll;
        tracker_h                = new();
        words_in                 = 0;
        steady_flow              = 1'b0;
        rst_n                    = 1'b0;
        request_bus.valid        = 1'b0;
        request_bus.operation    = stb_pkg::OP_TICK;
        request_bus.timer_slot   = '0;
        request_bus.reload_value = '0;
        request_bus.auto_reload  = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: undefined slots, zero reload, full-width reload, restart of a
        // running slot, auto-reload expiry, redefine while running, stop reloads count
        issue_plain(stb_pkg::OP_START, 4'd3);
        issue_plain(stb_pkg::OP_STOP, 4'd4);
        issue_plain(stb_pkg::OP_TICK, 4'd0);
        issue(stb_pkg::OP_DEFINE, 4'd0, 32'd0, 1'b0);
        issue_plain(stb_pkg::OP_START, 4'd0);
        issue_plain(stb_pkg::OP_TICK, 4'd0);
        issue(stb_pkg::OP_DEFINE, 4'd15, 32'hFFFF_FFFF, 1'b1);
        issue_plain(stb_pkg::OP_START, 4'd15);
        issue_plain(stb_pkg::OP_START, 4'd15);
        issue(stb_pkg::OP_DEFINE, 4'd1, 32'd2, 1'b1);
        issue_plain(stb_pkg::OP_START, 4'd1);
        issue_plain(stb_pkg::OP_TICK, 4'd7);
        issue_plain(stb_pkg::OP_TICK, 4'd8);
        issue_plain(stb_pkg::OP_TICK, 4'd9);
        issue(stb_pkg::OP_DEFINE, 4'd1, 32'd5, 1'b0);
        issue_plain(stb_pkg::OP_STOP, 4'd15);
        issue(stb_pkg::OP_DEFINE, 4'd2, 32'd3, 1'b0);
        issue_plain(stb_pkg::OP_START, 4'd2);
        issue_plain(stb_pkg::OP_TICK, 4'd2);
        issue_plain(stb_pkg::OP_STOP, 4'd2);
        issue_plain(stb_pkg::OP_START, 4'd2);
        issue_plain(stb_pkg::OP_TICK, 4'd2);
        issue_plain(stb_pkg::OP_TICK, 4'd2);
        issue_plain(stb_pkg::OP_TICK, 4'd2);

        // Random: defines and starts keep slots alive, ticks dominate so they expire;
        // stops and starts on unused slots act as noise
        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            if (n == 200)
                steady_flow <= 1'b1;
            else if (n == 260)
                steady_flow <= 1'b0;
            roll = $urandom_range(0, 99);
            if (roll < 15)
                issue(stb_pkg::OP_DEFINE, 4'($urandom), pick_reload(), 1'($urandom));
            else if (roll < 32)
                issue_plain(stb_pkg::OP_START, 4'($urandom));
            else if (roll < 40)
                issue_plain(stb_pkg::OP_STOP, 4'($urandom));
            else
                issue_plain(stb_pkg::OP_TICK, 4'($urandom));
        end
        request_bus.valid <= 1'b0;

        // Drain, then leave room for any stray result word
        while (tracker_h.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Covered %0d command words: %0d define, %0d start, %0d stop, %0d tick.",
                 words_in, tracker_h.op_count[stb_pkg::OP_DEFINE],
                 tracker_h.op_count[stb_pkg::OP_START],
                 tracker_h.op_count[stb_pkg::OP_STOP], tracker_h.op_count[stb_pkg::OP_TICK]);
        $display("%0d ticks expired a slot, %0d start/stop words hit an undefined slot, %s",
                 tracker_h.firing_ticks, tracker_h.undefined_hits,
                 $sformatf("%0d mismatches.", tracker_h.mismatches));
        if (tracker_h.mismatches == 0 && tracker_h.pending() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Receiver: random stalls, plus the long hold-off and the steady stretch
    initial
    begin : result_sink
        int unsigned stall_left;
        timer_result_t got;
        stall_left       = 0;
        result_bus.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_bus.valid && result_bus.ready)
            begin
                got.fired   = result_bus.fired_mask;
                got.running = result_bus.running_mask;
                got.status  = result_bus.status;
                tracker_h.check_result(got);
            end
            if (output_hold)
                result_bus.ready <= 1'b0;
            else if (steady_flow)
                result_bus.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                result_bus.ready <= 1'b0;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Hold the result side off for a long stretch while commands keep coming,
    // so the input register fills and ready drops
    initial
    begin : long_hold
        output_hold = 1'b0;
        wait (words_in >= HOLD_AT_WORD);
        @(posedge clk);
        output_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        output_hold <= 1'b0;
    end

    // Watchdog: end the run if no word moves on either channel for too long
    initial
    begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((request_bus.valid && request_bus.ready)
                || (result_bus.valid && result_bus.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Timeout: no word moved for %0d cycles.", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
